>>> sv/r2b_pkg.sv
// Shared types, constants and byte-formatting functions for the RGB565 to BMP writer.
package r2b_pkg;

  // Field widths
  localparam int PIX_W      = 16;
  localparam int BYTE_W     = 8;
  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int DIM_EXT_W  = 17;   // holds any dimension limit up to 65535

  // Parameter defaults
  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  // Register reset values
  localparam logic [CFG_W-1:0] WIDTH_RST  = 13'd320;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 13'd240;

  // Byte counter and stream layout
  localparam int IDX_W     = 6;
  localparam int HDR_LEN   = 54;
  localparam int PIX_BYTES = 3;

  // Header field offsets
  localparam logic [IDX_W-1:0] OFS_SIG_B   = 6'd0;
  localparam logic [IDX_W-1:0] OFS_SIG_M   = 6'd1;
  localparam logic [IDX_W-1:0] OFS_FSIZE   = 6'd2;
  localparam logic [IDX_W-1:0] OFS_DATA    = 6'd10;
  localparam logic [IDX_W-1:0] OFS_INFO    = 6'd14;
  localparam logic [IDX_W-1:0] OFS_WIDTH   = 6'd18;
  localparam logic [IDX_W-1:0] OFS_HEIGHT  = 6'd22;
  localparam logic [IDX_W-1:0] OFS_PLANES  = 6'd26;
  localparam logic [IDX_W-1:0] OFS_BPP     = 6'd28;
  localparam logic [IDX_W-1:0] OFS_ISIZE   = 6'd34;

  // Header constants
  localparam logic [7:0]  SIG_B      = 8'h42;
  localparam logic [7:0]  SIG_M      = 8'h4D;
  localparam logic [31:0] DATA_OFS   = 32'd54;
  localparam logic [31:0] INFO_SIZE  = 32'd40;
  localparam logic [7:0]  PLANES     = 8'd1;
  localparam logic [7:0]  BPP        = 8'd24;

  // Channel scaling: v*255/d computed as a reciprocal multiply
  localparam logic [7:0]  FULL_SCALE = 8'd255;
  localparam logic [13:0] RECIP31    = 14'd8457;   // ceil(2^18/31)
  localparam int          SHIFT31    = 18;
  localparam logic [14:0] RECIP63    = 15'd16645;  // ceil(2^20/63)
  localparam int          SHIFT63    = 20;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_HDR,
    ST_PIX,
    ST_PAD
  } ctl_state_e;

  typedef enum logic [1:0] {
    SEL_HDR,
    SEL_PIX,
    SEL_PAD
  } byte_sel_e;

  // Controller to datapath
  typedef struct packed {
    logic      load_pix;
    logic      calc;
    logic      clr_idx;
    logic      inc_idx;
    logic      emit;
    byte_sel_e sel;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic first;
    logic hdr_last;
    logic pix_last;
    logic pad_last;
    logic pad_none;
    logic out_free;
  } dp_status_t;

  // 5-bit channel to 8 bits, truncated
  function automatic logic [7:0] scale5(logic [4:0] v);
    logic [12:0] x;
    logic [26:0] p;
    x = 13'(v) * 13'(FULL_SCALE);
    p = 27'(x) * 27'(RECIP31);
    return p[SHIFT31 +: 8];
  endfunction

  // 6-bit channel to 8 bits, truncated
  function automatic logic [7:0] scale6(logic [5:0] v);
    logic [13:0] x;
    logic [28:0] p;
    x = 14'(v) * 14'(FULL_SCALE);
    p = 29'(x) * 29'(RECIP63);
    return p[SHIFT63 +: 8];
  endfunction

  // Little-endian byte of a 32-bit field starting at base
  function automatic logic [7:0] le_byte(logic [31:0] word, logic [IDX_W-1:0] pos,
                                         logic [IDX_W-1:0] base);
    logic [IDX_W-1:0] k;
    k = pos - base;
    return word[{k[1:0], 3'b000} +: 8];
  endfunction

  // One byte of the 54-byte header
  function automatic logic [7:0] hdr_byte(logic [IDX_W-1:0] idx, logic [31:0] w,
                                          logic [31:0] h, logic [31:0] img_size);
    logic [7:0] b;
    b = 8'h00;
    case (idx) inside
      OFS_SIG_B:                   b = SIG_B;
      OFS_SIG_M:                   b = SIG_M;
      [OFS_FSIZE:OFS_FSIZE+6'd3]:  b = le_byte(DATA_OFS + img_size, idx, OFS_FSIZE);
      [OFS_DATA:OFS_DATA+6'd3]:    b = le_byte(DATA_OFS, idx, OFS_DATA);
      [OFS_INFO:OFS_INFO+6'd3]:    b = le_byte(INFO_SIZE, idx, OFS_INFO);
      [OFS_WIDTH:OFS_WIDTH+6'd3]:  b = le_byte(w, idx, OFS_WIDTH);
      [OFS_HEIGHT:OFS_HEIGHT+6'd3]: b = le_byte(32'd0 - h, idx, OFS_HEIGHT);
      OFS_PLANES:                  b = PLANES;
      OFS_BPP:                     b = BPP;
      [OFS_ISIZE:OFS_ISIZE+6'd3]:  b = le_byte(img_size, idx, OFS_ISIZE);
      default:                     b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

>>> sv/r2b_pixel_if.sv
// Pixel input channel: valid/ready handshake with an RGB565 payload.
interface r2b_pixel_if;
  logic                       valid;
  logic                       ready;
  logic [r2b_pkg::PIX_W-1:0]  pixel_rgb565;

  modport source (output valid, output pixel_rgb565, input ready);
  modport sink   (input valid, input pixel_rgb565, output ready);
endinterface

>>> sv/r2b_byte_if.sv
// Byte output channel: valid/ready handshake with a BMP stream byte and markers.
interface r2b_byte_if;
  logic                        valid;
  logic                        ready;
  logic [r2b_pkg::BYTE_W-1:0]  out_byte;
  logic                        last_of_run;
  logic                        end_of_image;

  modport source (output valid, output out_byte, output last_of_run, output end_of_image,
                  input ready);
  modport sink   (input valid, input out_byte, input last_of_run, input end_of_image,
                  output ready);
endinterface

>>> sv/r2b_datapath.sv
// Datapath: config registers, frame counters, header math, byte formatting, output register.
module r2b_datapath #(
  parameter int MAX_WIDTH  = r2b_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = r2b_pkg::MAX_HEIGHT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  r2b_pkg::ctl_cmd_t             cmd_i,
  output r2b_pkg::dp_status_t           status_o,
  input  logic [r2b_pkg::PIX_W-1:0]     pixel_i,
  input  logic                          cfg_we_i,
  input  logic [r2b_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [r2b_pkg::CFG_W-1:0]     cfg_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [r2b_pkg::BYTE_W-1:0]    out_byte_o,
  output logic                          out_last_o,
  output logic                          out_eoi_o
);
  import r2b_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int BW = WW + 2;   // padded row bytes

  logic [CFG_W-1:0]     width_q, height_q;
  logic [CW-1:0]        col_q, col_d;
  logic [RW-1:0]        row_q, row_d;
  logic [PIX_W-1:0]     pix_q;
  logic                 frame_end_q;
  logic [1:0]           pad_q;
  logic [IDX_W-1:0]     idx_q;
  logic [31:0]          img_size_q;
  logic                 out_valid_q;
  logic [BYTE_W-1:0]    byte_q, byte_d;
  logic                 last_q, last_d;
  logic                 eoi_q;

  logic [DIM_EXT_W-1:0] w_ext, h_ext, w_lim, h_lim;
  logic [WW-1:0]        w;
  logic [HW-1:0]        h;
  logic [BW-1:0]        row_bytes;
  logic [BW+HW-1:0]     img_prod;
  logic                 row_end, frame_end;
  logic                 out_free;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        REG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp dimensions: zero acts as one, large values saturate
  always_comb begin
    w_ext = DIM_EXT_W'(width_q);
    h_ext = DIM_EXT_W'(height_q);
    if (width_q == '0) begin
      w_lim = DIM_EXT_W'(1);
    end else if (w_ext > DIM_EXT_W'(MAX_WIDTH)) begin
      w_lim = DIM_EXT_W'(MAX_WIDTH);
    end else begin
      w_lim = w_ext;
    end
    if (height_q == '0) begin
      h_lim = DIM_EXT_W'(1);
    end else if (h_ext > DIM_EXT_W'(MAX_HEIGHT)) begin
      h_lim = DIM_EXT_W'(MAX_HEIGHT);
    end else begin
      h_lim = h_ext;
    end
    w = WW'(w_lim);
    h = HW'(h_lim);
  end

  // Row and frame ends seen by the incoming pixel
  assign row_end   = ((WW+1)'(col_q) + (WW+1)'(1)) >= (WW+1)'(w);
  assign frame_end = row_end && (((HW+1)'(row_q) + (HW+1)'(1)) >= (HW+1)'(h));

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (frame_end) begin
      col_d = '0;
      row_d = '0;
    end else if (row_end) begin
      col_d = '0;
      row_d = row_q + RW'(1);
    end else begin
      col_d = col_q + CW'(1);
    end
  end

  // Frame counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.load_pix) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Per-pixel payload; pad count is (-3w) mod 4, which equals w mod 4
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_pix) begin
      pix_q       <= pixel_i;
      frame_end_q <= frame_end;
      pad_q       <= row_end ? 2'(w) : 2'd0;
    end
  end

  // Image size, one registered multiply at frame start
  assign row_bytes = ((BW'(w) * BW'(3)) + BW'(3)) & ~BW'(3);
  assign img_prod  = (BW+HW)'(row_bytes) * (BW+HW)'(h);

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      img_size_q <= 32'(img_prod);
    end
  end

  // Byte counter within the header, pixel or padding run
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.clr_idx) begin
      idx_q <= '0;
    end else if (cmd_i.inc_idx) begin
      idx_q <= idx_q + IDX_W'(1);
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    status_o.first    = (col_q == '0) && (row_q == '0);
    status_o.hdr_last = (idx_q == IDX_W'(HDR_LEN - 1));
    status_o.pix_last = (idx_q == IDX_W'(PIX_BYTES - 1));
    status_o.pad_last = ((idx_q[1:0] + 2'd1) == pad_q);
    status_o.pad_none = (pad_q == 2'd0);
    status_o.out_free = out_free;
  end

  // Next byte selection
  always_comb begin
    byte_d = '0;
    last_d = 1'b0;
    case (cmd_i.sel)
      SEL_HDR: begin
        byte_d = hdr_byte(idx_q, 32'(w), 32'(h), img_size_q);
      end
      SEL_PIX: begin
        case (idx_q[1:0])
          2'd0:    byte_d = scale5(pix_q[4:0]);
          2'd1:    byte_d = scale6(pix_q[10:5]);
          default: byte_d = scale5(pix_q[15:11]);
        endcase
        last_d = status_o.pix_last && status_o.pad_none;
      end
      SEL_PAD: begin
        byte_d = '0;
        last_d = status_o.pad_last;
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      byte_q <= byte_d;
      last_q <= last_d;
      eoi_q  <= last_d && frame_end_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;
  assign out_eoi_o   = eoi_q;

endmodule

>>> sv/r2b_ctrl.sv
// Controller: sequences header, pixel and padding bytes and the pixel handshake.
module r2b_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  r2b_pkg::dp_status_t status_i,
  output r2b_pkg::ctl_cmd_t   cmd_o
);
  import r2b_pkg::*;

  ctl_state_e state_q, state_d;
  logic       finish;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    finish      = 1'b0;
    cmd_o       = '0;
    cmd_o.sel   = SEL_HDR;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_pix = 1'b1;
          cmd_o.clr_idx  = 1'b1;
          state_d        = status_i.first ? ST_CALC : ST_PIX;
        end
      end
      ST_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = ST_HDR;
      end
      ST_HDR: begin
        if (status_i.out_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.sel     = SEL_HDR;
          cmd_o.inc_idx = 1'b1;
          if (status_i.hdr_last) begin
            cmd_o.clr_idx = 1'b1;
            state_d       = ST_PIX;
          end
        end
      end
      ST_PIX: begin
        if (status_i.out_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.sel     = SEL_PIX;
          cmd_o.inc_idx = 1'b1;
          if (status_i.pix_last) begin
            cmd_o.clr_idx = 1'b1;
            if (status_i.pad_none) begin
              finish = 1'b1;
            end else begin
              state_d = ST_PAD;
            end
          end
        end
      end
      ST_PAD: begin
        if (status_i.out_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.sel     = SEL_PAD;
          cmd_o.inc_idx = 1'b1;
          if (status_i.pad_last) begin
            cmd_o.clr_idx = 1'b1;
            finish        = 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // Last byte of a run goes out: take the next pixel in the same cycle
    if (finish) begin
      in_ready_o = 1'b1;
      state_d    = ST_IDLE;
      if (in_valid_i) begin
        cmd_o.load_pix = 1'b1;
        state_d        = status_i.first ? ST_CALC : ST_PIX;
      end
    end
  end

endmodule

>>> sv/rgb565_to_bmp24_stream_writer.sv
// Top level of the RGB565 to top-down 24-bit BMP byte stream writer.
// Pixels enter in raster order and leave as a BMP byte stream, one byte per cycle through
// an output register while the output is ready. A pixel yields its B, G and R bytes, plus
// 0 to 3 bytes of zero padding at a row end; the first pixel of a frame is preceded by the
// image-size multiply and then the 54 header bytes. The next pixel is taken in the cycle
// that its predecessor's last byte is loaded, so back-to-back pixels within a row are paced
// by the byte-wide output register. The user writes image_width and image_height through
// the config port only while the block is idle; the block itself does not enforce this.
// Zero acts as one and values above MAX_WIDTH / MAX_HEIGHT saturate.
module rgb565_to_bmp24_stream_writer #(
  parameter int MAX_WIDTH  = r2b_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = r2b_pkg::MAX_HEIGHT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  r2b_pixel_if.sink                     pixel_i,
  r2b_byte_if.source                    byte_o,
  input  logic                          cfg_we_i,
  input  logic [r2b_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [r2b_pkg::CFG_W-1:0]     cfg_data_i
);
  import r2b_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;

  // Sequencer
  r2b_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pixel_i.valid),
    .in_ready_o (pixel_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath
  r2b_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .pixel_i     (pixel_i.pixel_rgb565),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (byte_o.valid),
    .out_ready_i (byte_o.ready),
    .out_byte_o  (byte_o.out_byte),
    .out_last_o  (byte_o.last_of_run),
    .out_eoi_o   (byte_o.end_of_image)
  );

`ifndef SYNTHESIS
  // A byte is only loaded when the output register is free
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> status.out_free)
    else $error("byte loaded over a pending transaction");

  // A pixel is only latched on an accepted transaction
  a_load_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_pix |-> (pixel_i.valid && pixel_i.ready))
    else $error("pixel latched without a transaction");

  // End of image only on the last byte of a pixel run
  a_eoi_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (byte_o.valid && byte_o.end_of_image) |-> byte_o.last_of_run)
    else $error("end_of_image without last_of_run");
`endif

endmodule

>>> sim/r2b_bmp_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the BMP writer: predicts the byte stream per pixel and checks the output.
module r2b_bmp_checker #(
  parameter int MAX_WIDTH  = r2b_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = r2b_pkg::MAX_HEIGHT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  r2b_pixel_if                          pixel_i,
  r2b_byte_if                           byte_i,
  input  logic                          cfg_we_i,
  input  logic [r2b_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [r2b_pkg::CFG_W-1:0]     cfg_data_i,
  output int unsigned                   err_cnt_o,
  output int unsigned                   pending_o
);
  import r2b_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              eoi;
  } bmp_byte_t;

  // Bytes predicted but not yet seen on the output, oldest first
  bmp_byte_t        bmp_bytes_q[$];

  // Shadow geometry and raster position
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  int unsigned      col_cnt;
  int unsigned      row_cnt;

  // Zero acts as one, oversize saturates
  function automatic int unsigned clamp_dim(logic [CFG_W-1:0] v, int unsigned maxv);
    if (v == '0) return 1;
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

  task automatic push_byte(input logic [7:0] data, input logic last, input logic eoi);
    bmp_byte_t e;
    e.data = data;
    e.last = last;
    e.eoi  = eoi;
    bmp_bytes_q.push_back(e);
  endtask

  // Queue every byte one pixel produces: header on a frame start, BGR, row padding
  task automatic predict_pixel_bytes(input logic [PIX_W-1:0] pix);
    int unsigned w, h, pad, k;
    logic [31:0] row_bytes, img_size, fsize, neg_h;
    logic [7:0]  hb [HDR_LEN];
    logic [7:0]  bgr [3];
    logic        row_end, frame_end, fin;
    w         = clamp_dim(width_reg, MAX_WIDTH);
    h         = clamp_dim(height_reg, MAX_HEIGHT);
    row_bytes = (w * 3 + 3) & ~32'd3;
    row_end   = (col_cnt + 1 >= w);
    frame_end = row_end && (row_cnt + 1 >= h);
    pad       = row_end ? row_bytes - w * 3 : 0;

    if (col_cnt == 0 && row_cnt == 0) begin
      img_size = row_bytes * h;
      fsize    = img_size + 32'd54;
      neg_h    = 32'd0 - h;
      foreach (hb[i]) hb[i] = 8'h00;
      hb[OFS_SIG_B]  = SIG_B;
      hb[OFS_SIG_M]  = SIG_M;
      hb[OFS_PLANES] = PLANES;
      hb[OFS_BPP]    = BPP;
      for (k = 0; k < 4; k++) begin
        hb[OFS_FSIZE + k]  = fsize[8*k +: 8];
        hb[OFS_DATA + k]   = DATA_OFS[8*k +: 8];
        hb[OFS_INFO + k]   = INFO_SIZE[8*k +: 8];
        hb[OFS_WIDTH + k]  = w[8*k +: 8];
        hb[OFS_HEIGHT + k] = neg_h[8*k +: 8];
        hb[OFS_ISIZE + k]  = img_size[8*k +: 8];
      end
      for (k = 0; k < HDR_LEN; k++) push_byte(hb[k], 1'b0, 1'b0);
    end

    bgr[0] = 8'((int'(pix[4:0]) * 255) / 31);
    bgr[1] = 8'((int'(pix[10:5]) * 255) / 63);
    bgr[2] = 8'((int'(pix[15:11]) * 255) / 31);
    for (k = 0; k < 3; k++) begin
      fin = (k == 2) && (pad == 0);
      push_byte(bgr[k], fin, fin && frame_end);
    end
    for (k = 0; k < pad; k++) begin
      fin = (k + 1 == pad);
      push_byte(8'h00, fin, fin && frame_end);
    end

    // advance raster position
    if (frame_end) begin
      col_cnt = 0;
      row_cnt = 0;
    end else if (row_end) begin
      col_cnt = 0;
      row_cnt = row_cnt + 1;
    end else begin
      col_cnt = col_cnt + 1;
    end
  endtask

  task automatic note_mismatch(input string msg);
    err_cnt_o = err_cnt_o + 1;
    if (err_cnt_o <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // Track config writes, predict on pixel transactions, compare on byte transactions
  always @(posedge clk_i or negedge rst_ni) begin
    bmp_byte_t want, got;
    if (!rst_ni) begin
      width_reg  = WIDTH_RST;
      height_reg = HEIGHT_RST;
      col_cnt    = 0;
      row_cnt    = 0;
      bmp_bytes_q.delete();
      err_cnt_o  = 0;
      pending_o  = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_IMAGE_WIDTH) width_reg = cfg_data_i;
        else if (cfg_idx_i == REG_IMAGE_HEIGHT) height_reg = cfg_data_i;
      end
      if (pixel_i.valid && pixel_i.ready) predict_pixel_bytes(pixel_i.pixel_rgb565);
      if (byte_i.valid && byte_i.ready) begin
        got.data = byte_i.out_byte;
        got.last = byte_i.last_of_run;
        got.eoi  = byte_i.end_of_image;
        if (bmp_bytes_q.size() == 0) begin
          note_mismatch($sformatf("unexpected byte %02h last %0b eoi %0b",
                                  got.data, got.last, got.eoi));
        end else begin
          want = bmp_bytes_q.pop_front();
          if (got !== want)
            note_mismatch($sformatf({"byte mismatch: expected %02h last %0b eoi %0b,",
                                     " got %02h last %0b eoi %0b"},
                                    want.data, want.last, want.eoi,
                                    got.data, got.last, got.eoi));
        end
      end
      pending_o = bmp_bytes_q.size();
    end
  end

endmodule

>>> sim/rgb565_to_bmp24_stream_writer_tb.sv
`timescale 1ns / 100ps
// Testbench top for the BMP writer: pixel stimulus, geometry writes, output stalls, verdict.
module rgb565_to_bmp24_stream_writer_tb;
  import r2b_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 5000000;
  localparam int unsigned RANDOM_PIXELS = 420;

  typedef enum int {
    RDY_FULL,
    RDY_RANDOM,
    RDY_STALL
  } ready_mode_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  int unsigned mismatch_cnt;
  int unsigned bytes_pending;
  int unsigned cycle_cnt = 0;
  int unsigned random_sent = 0;
  bit          no_idle = 1'b0;

  ready_mode_e ready_mode = RDY_FULL;
  int unsigned ready_left = 0;

  r2b_pixel_if pix_if ();
  r2b_byte_if  byte_if ();

  rgb565_to_bmp24_stream_writer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pixel_i    (pix_if),
    .byte_o     (byte_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  r2b_bmp_checker u_bmp_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pixel_i    (pix_if),
    .byte_i     (byte_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .err_cnt_o  (mismatch_cnt),
    .pending_o  (bytes_pending)
  );

  always #1 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("rgb565_to_bmp24_stream_writer test failed");
      $finish;
    end
  end

  // Output backpressure: stretches of full rate, random ready, short and long stalls
  always @(posedge clk_i) begin
    int unsigned r;
    if (ready_left == 0) begin
      r = $urandom_range(0, 9);
      if (r < 4) begin
        ready_mode = RDY_FULL;
        ready_left = $urandom_range(20, 80);
      end else if (r < 8) begin
        ready_mode = RDY_RANDOM;
        ready_left = $urandom_range(10, 40);
      end else begin
        ready_mode = RDY_STALL;
        ready_left = (r == 8) ? $urandom_range(1, 4) : $urandom_range(15, 50);
      end
    end else begin
      ready_left = ready_left - 1;
    end
    case (ready_mode)
      RDY_FULL:   byte_if.ready <= 1'b1;
      RDY_RANDOM: byte_if.ready <= ($urandom_range(0, 9) < 7);
      default:    byte_if.ready <= 1'b0;
    endcase
  end

  // Mostly back-to-back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Present one pixel and hold it until the transaction completes
  task automatic send_pixel(input logic [PIX_W-1:0] value);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_if.valid        <= 1'b1;
    pix_if.pixel_rgb565 <= value;
    do @(posedge clk_i); while (!pix_if.ready);
  endtask

  // Stop sending and wait until every predicted byte has come out
  task automatic drain();
    pix_if.valid <= 1'b0;
    do @(posedge clk_i); while (bytes_pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
  endtask

  initial begin
    logic [PIX_W-1:0] corner_pix [7];
    logic [PIX_W-1:0] pix;
    int unsigned      r, n, w, h;

    corner_pix = '{16'h0000, 16'hFFFF, 16'hF800, 16'h07E0, 16'h001F, 16'hAAAA, 16'h5555};

    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = REG_IMAGE_WIDTH;
    cfg_data_i          = '0;
    pix_if.valid        = 1'b0;
    pix_if.pixel_rgb565 = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // header built from the reset geometry
    send_pixel(16'h0000);
    send_pixel(16'hFFFF);
    drain();

    // one-pixel frames: channel extremes, each with header and one pad byte
    set_frame(13'd1, 13'd1);
    foreach (corner_pix[i]) send_pixel(corner_pix[i]);
    drain();

    // zero geometry behaves as 1 x 1
    set_frame(13'd0, 13'd0);
    send_pixel(16'h1234);
    send_pixel(16'hFEDC);
    drain();

    // two and three bytes of row padding
    set_frame(13'd2, 13'd2);
    repeat (4) send_pixel(16'($urandom_range(0, 65535)));
    drain();
    set_frame(13'd3, 13'd1);
    repeat (3) send_pixel(16'($urandom_range(0, 65535)));
    drain();

    // oversize geometry saturates to the maximum
    set_frame(13'h1FFF, 13'h1FFF);
    send_pixel(16'hFFFF);
    send_pixel(16'h0000);
    drain();

    // shrink mid-frame: column past the new width ends the row, then the frame
    write_reg(REG_IMAGE_WIDTH, 13'd1);
    send_pixel(16'h8421);
    drain();
    write_reg(REG_IMAGE_HEIGHT, 13'd1);
    send_pixel(16'h7BDE);
    drain();

    // exact maximum, left open for the random part to cut short
    set_frame(13'd4096, 13'd4096);
    send_pixel(16'hC3A5);
    drain();

    // random phases, mostly small complete frames
    while (random_sent < RANDOM_PIXELS) begin
      r = $urandom_range(0, 19);
      if (r < 14) begin
        w = $urandom_range(1, 8);
        h = $urandom_range(1, 4);
        set_frame(13'(w), 13'(h));
        n = w * h * $urandom_range(1, 2) + $urandom_range(0, 3);
      end else if (r < 16) begin
        // change one register with a frame possibly in flight
        if ($urandom_range(0, 1) == 0) write_reg(REG_IMAGE_WIDTH, 13'($urandom_range(0, 9)));
        else write_reg(REG_IMAGE_HEIGHT, 13'($urandom_range(0, 5)));
        n = $urandom_range(1, 12);
      end else if (r < 19) begin
        w = $urandom_range(9, 40);
        h = $urandom_range(1, 2);
        set_frame(13'(w), 13'(h));
        n = $urandom_range(1, w * h);
      end else begin
        set_frame(13'($urandom_range(0, 8191)), 13'($urandom_range(0, 8191)));
        n = $urandom_range(1, 5);
      end
      no_idle = ($urandom_range(0, 3) == 0);
      repeat (n) begin
        case ($urandom_range(0, 15))
          0:       pix = 16'h0000;
          1:       pix = 16'hFFFF;
          2:       pix = 16'hF800;
          3:       pix = 16'h07E0;
          4:       pix = 16'h001F;
          default: pix = 16'($urandom_range(0, 65535));
        endcase
        send_pixel(pix);
        random_sent = random_sent + 1;
      end
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0 && bytes_pending == 0) begin
      $display("rgb565_to_bmp24_stream_writer test passed");
    end else begin
      $display("rgb565_to_bmp24_stream_writer test failed");
    end
    $finish;
  end

endmodule
